// File: rtl/core/utli_pkg.sv
//==============================================================================
// utli_pkg
// Shared widths, command codes and register indexes for the uniform table
// linear interpolator.
//==============================================================================
`default_nettype none

package utli_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;

    localparam int DATA_W      = 32;  // Q16.16 depth samples and results
    localparam int POS_W       = 24;  // Q4.20 query position
    localparam int IDX_W       = 10;  // entry index field
    localparam int COUNT_W     = 11;  // entry_count register
    localparam int FRAC_W      = 20;  // fraction bits of the scaled position
    localparam int CHUNK_W     = 16;  // slice of t per multiply step
    localparam int QUEUE_DEPTH = 4;   // command queue between front and back
    localparam int CFG_IDX_W   = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_EDGES  = 2'd1;

    // Request type codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Commands handed from the front to the back
    typedef enum logic [1:0] {
        OP_WRITE,   // store one table entry
        OP_EDGE,    // return one stored entry as is
        OP_INTERP   // interpolate from an entry and its upper neighbor
    } op_t;

endpackage

`default_nettype wire

// File: rtl/core/uniform_table_linear_interp.sv
// Timing: a write passes the front stage register and the command queue before the back end
//   stores it; a query also passes the table read registers and the result registers, and an
//   interpolating query adds K = ceil((log2(MAX_ENTRIES) + 25) / 16) partial products.
// Overlap: the back end pops a new command only once the last one is done, and builds the
//   partial products one after another on the shared 33x17 multiply-accumulate loop.
// Reset: a clearing pass zeroes every table entry; full stays high meanwhile.
//==============================================================================
// uniform_table_linear_interp
// Piecewise linear interpolation over a uniformly spaced table of Q16.16
// depth samples, queried with a Q4.20 normalized position.
//==============================================================================
`default_nettype none

module uniform_table_linear_interp
    import utli_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // request queue side
    input  wire logic                      push,
    output logic                           full,
    input  wire logic                      req_type,
    input  wire logic [IDX_W-1:0]          entry_index,
    input  wire logic signed [DATA_W-1:0]  entry_value,
    input  wire logic signed [POS_W-1:0]   position,
    // result queue side
    output logic                           empty,
    input  wire logic                      pop,
    output logic signed [DATA_W-1:0]       value_out,
    output logic                           overflow,
    // configuration write channel
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [COUNT_W-1:0]        cfg_data
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int SW = AW + POS_W + 1;
    localparam int QW = 2 + AW + SW + DATA_W;

    logic [COUNT_W-1:0] entry_count_reg;
    logic               hold_edges_reg;

    logic               clearing;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    logic [QW-1:0]      q_wdata;
    logic [QW-1:0]      q_rdata;

    // Configuration: always ready, one register per beat. Writes are expected
    // only while the datapath is idle, so no shadowing is needed.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= COUNT_W'(1);
            hold_edges_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data;
                CFG_HOLD_EDGES:  hold_edges_reg  <= cfg_data[0];
                default:         ;  // hold: unmapped index
            endcase
        end
    end

    // Front end: one request beat per cycle, unless full (clearing or queue stalled), into a stage
    // register that holds the scaled position span * position. The stage classifies the request
    // (table write, edge read, interpolation) and pushes a command. Writes to
    // entries beyond the count in use are dropped here.
    utli_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .position    (position),
        .entry_count (entry_count_reg),
        .hold_edges  (hold_edges_reg),
        .clearing    (clearing),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    // Command queue: lets the front keep taking beats while the back end
    // runs a multi-cycle interpolation or waits on a full result register.
    utli_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .wdata (q_wdata),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    // Back end: owns the table memory (one write port, two registered read
    // ports), clears it after reset, then executes commands in order so a
    // query always sees every earlier write. The interpolation product
    // t * (d[i+1] - d[i]) is built from 16-bit slices of t, top slice first,
    // and floored by an arithmetic shift before the add and saturation.
    utli_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_rdata),
        .clearing  (clearing),
        .empty     (empty),
        .pop       (pop),
        .value_out (value_out),
        .overflow  (overflow)
    );

endmodule

`default_nettype wire

// File: rtl/core/utli_front.sv
//==============================================================================
// utli_front
// Accepts request beats, scales the query position by the table span and
// classifies each request into a back-end command.
//==============================================================================
`default_nettype none

module utli_front
    import utli_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // request side
    input  wire logic                        push,
    output logic                             full,
    input  wire logic                        req_type,
    input  wire logic [IDX_W-1:0]            entry_index,
    input  wire logic signed [DATA_W-1:0]    entry_value,
    input  wire logic signed [POS_W-1:0]     position,
    // configuration
    input  wire logic [COUNT_W-1:0]          entry_count,
    input  wire logic                        hold_edges,
    input  wire logic                        clearing,
    // command queue
    input  wire logic                        q_full,
    output logic                             q_push,
    output logic [2+$clog2(MAX_ENTRIES)+($clog2(MAX_ENTRIES)+POS_W+1)+DATA_W-1:0] q_data
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int SW = AW + POS_W + 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

    logic [XW-1:0]          cnt_x;
    logic [XW-1:0]          eff;
    logic [AW-1:0]          span;
    logic [AW-1:0]          span_m1;
    logic signed [SW-1:0]   s_prod;

    logic                   a_valid_reg, a_valid_next;
    logic                   a_type_reg;
    logic [IDX_W-1:0]       a_idx_reg;
    logic [DATA_W-1:0]      a_val_reg;
    logic signed [SW-1:0]   a_s_reg;

    logic                   accept;
    logic                   advance;
    logic                   keep;
    logic                   below;
    logic                   above;
    logic signed [SW-1:0]   span_q;
    logic signed [SW-1:0]   span_m1_q;
    logic signed [SW-1:0]   t_above;
    op_t                    op;
    logic [AW-1:0]          addr;
    logic signed [SW-1:0]   tval;

    // Clamp the configured count into 1..MAX_ENTRIES
    always_comb
    begin
        cnt_x = XW'(entry_count);
        if (cnt_x == '0)
            eff = XW'(1);
        else if (cnt_x > XW'(MAX_ENTRIES))
            eff = XW'(MAX_ENTRIES);
        else
            eff = cnt_x;
    end

    assign span    = AW'(eff - XW'(1));
    assign span_m1 = span - AW'(1);
    assign s_prod  = $signed({1'b0, span}) * position;

    assign full    = clearing || (a_valid_reg && q_full);
    assign accept  = push && !full;
    assign advance = a_valid_reg && !q_full;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
            a_valid_next = 1'b1;
        else if (advance)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_type_reg <= req_type;
            a_idx_reg  <= entry_index;
            a_val_reg  <= entry_value;
            a_s_reg    <= s_prod;
        end
    end

    // Segment selection on the scaled position
    assign span_q    = $signed({{(SW-AW-FRAC_W){1'b0}}, span, {FRAC_W{1'b0}}});
    assign span_m1_q = $signed({{(SW-AW-FRAC_W){1'b0}}, span_m1, {FRAC_W{1'b0}}});
    assign t_above   = a_s_reg - span_m1_q;
    assign below     = a_s_reg[SW-1];
    assign above     = !below && (a_s_reg >= span_q);

    always_comb
    begin
        op   = OP_WRITE;
        addr = AW'(a_idx_reg);
        tval = '0;
        keep = 1'b1;
        if (a_type_reg == REQ_WRITE)
        begin
            // drop writes beyond the entries in use
            keep = XW'(a_idx_reg) < eff;
        end
        else if (span == '0)
        begin
            op   = OP_EDGE;
            addr = '0;
        end
        else if (below)
        begin
            addr = '0;
            if (hold_edges)
                op = OP_EDGE;
            else
            begin
                op   = OP_INTERP;
                tval = a_s_reg;
            end
        end
        else if (above)
        begin
            if (hold_edges)
            begin
                op   = OP_EDGE;
                addr = span;
            end
            else
            begin
                op   = OP_INTERP;
                addr = span_m1;
                tval = t_above;
            end
        end
        else
        begin
            op   = OP_INTERP;
            addr = a_s_reg[AW+FRAC_W-1:FRAC_W];
            tval = $signed({{(SW-FRAC_W){1'b0}}, a_s_reg[FRAC_W-1:0]});
        end
    end

    assign q_push = advance && keep;
    assign q_data = {op, addr, tval, a_val_reg};

endmodule

`default_nettype wire

// File: rtl/core/utli_fifo.sv
//==============================================================================
// utli_fifo
// Small command queue that decouples the front end from the back end.
//==============================================================================
`default_nettype none

module utli_fifo
    import utli_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      rdata
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == (PTR_W+1)'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + (PTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

// File: rtl/core/utli_back.sv
//==============================================================================
// utli_back
// Owns the sample table, clears it after reset and executes commands:
// table writes, edge reads and multi-step interpolation with saturation.
//==============================================================================
`default_nettype none

module utli_back
    import utli_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // command queue
    input  wire logic                        q_empty,
    output logic                             q_pop,
    input  wire logic [2+$clog2(MAX_ENTRIES)+($clog2(MAX_ENTRIES)+POS_W+1)+DATA_W-1:0] q_data,
    output logic                             clearing,
    // result side
    output logic                             empty,
    input  wire logic                        pop,
    output logic signed [DATA_W-1:0]         value_out,
    output logic                             overflow
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int SW   = AW + POS_W + 1;
    localparam int QW   = 2 + AW + SW + DATA_W;
    localparam int K    = (SW + CHUNK_W - 1) / CHUNK_W;
    localparam int KCW  = $clog2(K);
    localparam int TW   = K * CHUNK_W;
    localparam int DW1  = DATA_W + 1;
    localparam int PRW  = DW1 + CHUNK_W + 1;
    localparam int ACW  = TW + DW1;
    localparam int SUMW = ACW - FRAC_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_SUM,
        ST_SAT,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [AW-1:0]          clr_cnt_reg;
    logic [KCW-1:0]         k_reg;
    logic                   out_valid_reg;

    logic [DATA_W-1:0]      mem [MAX_ENTRIES];
    logic [DATA_W-1:0]      rd_a_reg;
    logic [DATA_W-1:0]      rd_b_reg;

    op_t                    op_reg;
    logic signed [SW-1:0]   t_reg;
    logic signed [DATA_W-1:0] d1_reg;
    logic signed [DW1-1:0]  diff_reg;
    logic signed [PRW-1:0]  prod_reg;
    logic signed [ACW-1:0]  acc_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [DATA_W-1:0]      res_val_reg;
    logic                   res_ovf_reg;
    logic [DATA_W-1:0]      out_val_reg;
    logic                   out_ovf_reg;

    op_t                    q_op;
    logic [AW-1:0]          q_addr;
    logic signed [SW-1:0]   q_t;
    logic [DATA_W-1:0]      q_wdata;

    logic                   mem_we;
    logic                   mem_re;
    logic [AW-1:0]          mem_waddr;
    logic [DATA_W-1:0]      mem_wdata;
    logic                   out_load;

    logic signed [TW-1:0]   t_ext;
    logic [CHUNK_W-1:0]     chunk_bits;
    logic signed [CHUNK_W:0] chunk_s;
    logic signed [PRW-1:0]  mul_res;
    logic [SUMW-DATA_W:0]   sum_hi;

    assign q_op    = op_t'(q_data[QW-1 -: 2]);
    assign q_addr  = q_data[QW-3 -: AW];
    assign q_t     = $signed(q_data[DATA_W +: SW]);
    assign q_wdata = q_data[DATA_W-1:0];

    assign clearing  = state_reg == ST_CLEAR;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign mem_we    = clearing || (q_pop && q_op == OP_WRITE);
    assign mem_re    = q_pop && q_op != OP_WRITE;
    assign mem_waddr = clearing ? clr_cnt_reg : q_addr;
    assign mem_wdata = clearing ? '0 : q_wdata;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || pop);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
        begin
            rd_a_reg <= mem[q_addr];
            rd_b_reg <= mem[q_addr + AW'(1)];
        end
    end

    // One slice of t per multiply step, top slice signed
    assign t_ext      = TW'(t_reg);
    assign chunk_bits = t_ext[k_reg*CHUNK_W +: CHUNK_W];
    assign chunk_s    = $signed({(k_reg == KCW'(K-1)) ? chunk_bits[CHUNK_W-1] : 1'b0,
                                 chunk_bits});
    assign mul_res    = diff_reg * chunk_s;
    assign sum_hi     = sum_reg[SUMW-1:DATA_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(MAX_ENTRIES-1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (mem_re)
                        state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    k_reg <= KCW'(K-1);
                    state_reg <= (op_reg == OP_INTERP) ? ST_MUL : ST_OUT;
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (k_reg == '0)
                        state_reg <= ST_SUM;
                    else
                    begin
                        k_reg     <= k_reg - KCW'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_SUM:
                begin
                    state_reg <= ST_SAT;
                end
                ST_SAT:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            op_reg <= q_op;
            t_reg  <= q_t;
        end
        if (state_reg == ST_READ)
        begin
            d1_reg      <= $signed(rd_a_reg);
            diff_reg    <= $signed({rd_b_reg[DATA_W-1], rd_b_reg})
                         - $signed({rd_a_reg[DATA_W-1], rd_a_reg});
            res_val_reg <= rd_a_reg;
            res_ovf_reg <= 1'b0;
            acc_reg     <= '0;
        end
        if (state_reg == ST_MUL)
            prod_reg <= mul_res;
        if (state_reg == ST_ACC)
            acc_reg <= (acc_reg <<< CHUNK_W) + ACW'(prod_reg);
        if (state_reg == ST_SUM)
            sum_reg <= SUMW'(d1_reg) + SUMW'(acc_reg >>> FRAC_W);
        if (state_reg == ST_SAT)
        begin
            // saturate when the upper bits are not all sign copies
            if (~|sum_hi || &sum_hi)
            begin
                res_val_reg <= sum_reg[DATA_W-1:0];
                res_ovf_reg <= 1'b0;
            end
            else if (sum_reg[SUMW-1])
            begin
                res_val_reg <= {1'b1, {(DATA_W-1){1'b0}}};
                res_ovf_reg <= 1'b1;
            end
            else
            begin
                res_val_reg <= {1'b0, {(DATA_W-1){1'b1}}};
                res_ovf_reg <= 1'b1;
            end
        end
        if (out_load)
        begin
            out_val_reg <= res_val_reg;
            out_ovf_reg <= res_ovf_reg;
        end
    end

    assign empty     = !out_valid_reg;
    assign value_out = $signed(out_val_reg);
    assign overflow  = out_ovf_reg;

endmodule

`default_nettype wire
